// ===== design/cda_pkg.sv =====
// Shared types, constants and calendar tables for the date arithmetic core.
`default_nettype none

package cda_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonW  = 4;
  localparam int unsigned DayW  = 5;
  localparam int unsigned OffW  = 23;
  localparam int unsigned SerW  = 22;  // day serial of a valid date
  localparam int unsigned AccW  = 24;  // serial plus signed offset
  localparam int unsigned RemW  = 9;   // day within a year
  localparam int unsigned CumW  = 9;
  localparam int unsigned Q100W = 7;

  localparam logic [YearW-1:0] MaxYear       = 14'd9999;
  localparam logic [MonW-1:0]  MonthsPerYear = 4'd12;
  localparam logic [MonW-1:0]  February      = 4'd2;
  localparam logic [SerW-1:0]  YearsEnd      = 22'd3652059;  // serial of 10000-01-01

  // v / 100 as (v * Recip100) >> Shift100, exact for v below 43690
  localparam logic [12:0] Recip100 = 13'd5243;
  localparam int unsigned Shift100 = 19;
  localparam int unsigned Q100ProdW = YearW + 13;

  // n / 365.2425 from below as (n * RecipYear) >> ShiftYear
  localparam logic [15:0] RecipYear  = 16'd45934;
  localparam int unsigned ShiftYear  = 24;
  localparam int unsigned EstProdW   = SerW + 16;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_MUL,
    S_A_SUM,
    S_A_SER,
    S_B_MUL,
    S_B_SUM,
    S_B_SER,
    S_RANGE,
    S_EST,
    S_EST_APPLY,
    S_W_MUL,
    S_W_SUM,
    S_W_CHK,
    S_MONTH,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_BAD,
    RES_RANGE,
    RES_DATE,
    RES_DIFF
  } res_kind_e;

  typedef enum logic [2:0] {
    V_HOLD,
    V_A,
    V_B,
    V_EST,
    V_INC
  } v_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD_A,
    ACC_SUB_B
  } acc_op_e;

  typedef struct packed {
    logic      load_in;
    v_sel_e    v_sel;
    logic      sel_b;
    acc_op_e   acc_op;
    logic      est_load;
    logic      base_load;
    logic      month_init;
    logic      month_step;
    logic      out_load;
    res_kind_e out_kind;
  } cmd_t;

  typedef struct packed {
    logic op_diff;
    logic date_ok;
    logic acc_oor;
    logic y_le_n;
    logic month_more;
  } status_t;

  function automatic logic [DayW-1:0] month_days(logic [MonW-1:0] m, logic leap);
    logic [DayW-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days in the year before the first of month m
  function automatic logic [CumW-1:0] cum_days(logic [MonW-1:0] m);
    logic [CumW-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/cda_dpath.sv =====
// Datapath: operand capture, year-start unit, serial accumulator, walks, result register.
`default_nettype none

module cda_dpath import cda_pkg::*; (
  input  logic                   clk_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic                   opcode_i,
  input  logic [YearW-1:0]       a_year_i,
  input  logic [MonW-1:0]        a_month_i,
  input  logic [DayW-1:0]        a_day_i,
  input  logic [YearW-1:0]       b_year_i,
  input  logic [MonW-1:0]        b_month_i,
  input  logic [DayW-1:0]        b_day_i,
  input  logic signed [OffW-1:0] day_offset_i,
  output logic [YearW-1:0]       res_year_o,
  output logic [MonW-1:0]        res_month_o,
  output logic [DayW-1:0]        res_day_o,
  output logic signed [OffW-1:0] day_difference_o,
  output logic                   a_before_b_o,
  output logic                   bad_date_o,
  output logic                   out_of_range_o
);

  logic                   op_q;
  logic [YearW-1:0]       a_year_q, b_year_q;
  logic [MonW-1:0]        a_month_q, b_month_q;
  logic [DayW-1:0]        a_day_q, b_day_q;
  logic signed [OffW-1:0] off_q;

  logic [YearW-1:0] v_q, v_d;
  logic [Q100W-1:0] q100_q;
  logic [SerW-1:0]  p365_q, ystart_q, ystart_d, base_q;
  logic             leap_q, leap_d, leapy_q;
  logic [AccW-1:0]  acc_q, acc_d;
  logic [YearW-1:0] est_q;
  logic [RemW-1:0]  rem_q;
  logic [MonW-1:0]  mm_q;

  logic [Q100ProdW-1:0] q100_prod;
  logic [YearW+8:0]     p365_prod;
  logic [YearW-1:0]     hund, rem100;
  logic [EstProdW-1:0]  est_prod;

  logic [YearW-1:0] dy;
  logic [MonW-1:0]  dm;
  logic [DayW-1:0]  dd, dim, dim_walk;
  logic             leap_adj;
  logic [SerW-1:0]  serial;
  logic [AccW-1:0]  off_ext;

  // Capture operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= opcode_i;
      a_year_q  <= a_year_i;
      a_month_q <= a_month_i;
      a_day_q   <= a_day_i;
      b_year_q  <= b_year_i;
      b_month_q <= b_month_i;
      b_day_q   <= b_day_i;
      off_q     <= day_offset_i;
    end
  end

  // Year operand v: the unit gives days before year v+1 and whether v+1 is leap.
  always_comb begin
    unique case (cmd_i.v_sel)
      V_A:     v_d = a_year_i - YearW'(1);
      V_B:     v_d = b_year_q - YearW'(1);
      V_EST:   v_d = (est_q != '0) ? est_q - YearW'(1) : '0;
      V_INC:   v_d = v_q + YearW'(1);
      default: v_d = v_q;
    endcase
  end

  // Stage one: constant products.
  assign q100_prod = Q100ProdW'(v_q) * Q100ProdW'(Recip100);
  assign p365_prod = (YearW+9)'(v_q) * (YearW+9)'(365);

  // Stage two: year start and leap flag.
  assign hund     = YearW'(q100_q) * YearW'(100);
  assign rem100   = v_q - hund;
  assign ystart_d = p365_q + SerW'(v_q >> 2) - SerW'(q100_q) + SerW'(q100_q >> 2);
  assign leap_d   = (v_q[1:0] == 2'b11) &&
                    ((rem100 != YearW'(99)) || (q100_q[1:0] == 2'b11));

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    q100_q   <= q100_prod[Shift100 +: Q100W];
    p365_q   <= p365_prod[SerW-1:0];
    ystart_q <= ystart_d;
    leap_q   <= leap_d;
  end

  // Date check and serial of the selected date.
  assign dy       = cmd_i.sel_b ? b_year_q  : a_year_q;
  assign dm       = cmd_i.sel_b ? b_month_q : a_month_q;
  assign dd       = cmd_i.sel_b ? b_day_q   : a_day_q;
  assign dim      = month_days(dm, leap_q);
  assign leap_adj = leap_q && (dm > February);
  assign serial   = ystart_q + SerW'(cum_days(dm)) + SerW'(leap_adj) + SerW'(dd) - SerW'(1);
  assign off_ext  = op_q ? '0 : {{(AccW-OffW){off_q[OffW-1]}}, off_q};

  always_comb begin
    unique case (cmd_i.acc_op)
      ACC_LOAD_A: acc_d = AccW'(serial) + off_ext;
      ACC_SUB_B:  acc_d = acc_q - AccW'(serial);
      default:    acc_d = acc_q;
    endcase
  end

  assign est_prod = EstProdW'(acc_q[SerW-1:0]) * EstProdW'(RecipYear);
  assign dim_walk = month_days(mm_q, leapy_q);

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.est_load) begin
      est_q <= est_prod[ShiftYear +: YearW];
    end
    if (cmd_i.base_load) begin
      base_q  <= ystart_q;
      leapy_q <= leap_q;
    end
    if (cmd_i.month_init) begin
      rem_q <= RemW'(acc_q[SerW-1:0] - base_q);
      mm_q  <= MonW'(1);
    end else if (cmd_i.month_step) begin
      rem_q <= rem_q - RemW'(dim_walk);
      mm_q  <= mm_q + MonW'(1);
    end
  end

  assign status_o.op_diff    = op_q;
  assign status_o.date_ok    = (dy != '0) && (dy <= MaxYear) && (dm != '0) &&
                               (dm <= MonthsPerYear) && (dd != '0) && (dd <= dim);
  assign status_o.acc_oor    = acc_q[AccW-1] || (acc_q >= AccW'(YearsEnd));
  assign status_o.y_le_n     = ystart_q <= acc_q[SerW-1:0];
  assign status_o.month_more = (mm_q < MonthsPerYear) && (rem_q >= RemW'(dim_walk));

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_year_o       <= '0;
      res_month_o      <= '0;
      res_day_o        <= '0;
      day_difference_o <= '0;
      a_before_b_o     <= 1'b0;
      bad_date_o       <= 1'b0;
      out_of_range_o   <= 1'b0;
      unique case (cmd_i.out_kind)
        RES_BAD:   bad_date_o     <= 1'b1;
        RES_RANGE: out_of_range_o <= 1'b1;
        RES_DATE: begin
          res_year_o  <= v_q;
          res_month_o <= mm_q;
          res_day_o   <= DayW'(rem_q + RemW'(1));
        end
        default: begin
          day_difference_o <= acc_q[OffW-1:0];
          a_before_b_o     <= acc_q[AccW-1];
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/cda_ctrl.sv =====
// Controller: sequencing state machine and result valid flag.
`default_nettype none

module cda_ctrl import cda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e    state_q, state_d;
  res_kind_e kind_q, kind_d;
  logic      out_valid_q, out_valid_d;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_A_MUL;
      S_A_MUL: state_d = S_A_SUM;
      S_A_SUM: state_d = S_A_SER;
      S_A_SER: begin
        if (!status_i.date_ok) begin
          kind_d  = RES_BAD;
          state_d = S_DONE;
        end else if (status_i.op_diff) begin
          state_d = S_B_MUL;
        end else begin
          state_d = S_RANGE;
        end
      end
      S_B_MUL: state_d = S_B_SUM;
      S_B_SUM: state_d = S_B_SER;
      S_B_SER: begin
        kind_d  = status_i.date_ok ? RES_DIFF : RES_BAD;
        state_d = S_DONE;
      end
      S_RANGE: begin
        if (status_i.acc_oor) begin
          kind_d  = RES_RANGE;
          state_d = S_DONE;
        end else begin
          state_d = S_EST;
        end
      end
      S_EST:       state_d = S_EST_APPLY;
      S_EST_APPLY: state_d = S_W_MUL;
      S_W_MUL:     state_d = S_W_SUM;
      S_W_SUM:     state_d = S_W_CHK;
      S_W_CHK:     state_d = status_i.y_le_n ? S_W_MUL : S_MONTH;
      S_MONTH: begin
        if (!status_i.month_more) begin
          kind_d  = RES_DATE;
          state_d = S_DONE;
        end
      end
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.v_sel    = V_HOLD;
    cmd_o.acc_op   = ACC_HOLD;
    cmd_o.out_kind = kind_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load_in = in_valid_i;
        cmd_o.v_sel   = in_valid_i ? V_A : V_HOLD;
      end
      S_A_SER: begin
        cmd_o.acc_op = ACC_LOAD_A;
        cmd_o.v_sel  = V_B;
      end
      S_B_SER: begin
        cmd_o.sel_b  = 1'b1;
        cmd_o.acc_op = ACC_SUB_B;
      end
      S_EST:       cmd_o.est_load = 1'b1;
      S_EST_APPLY: cmd_o.v_sel    = V_EST;
      S_W_CHK: begin
        if (status_i.y_le_n) begin
          cmd_o.base_load = 1'b1;
          cmd_o.v_sel     = V_INC;
        end else begin
          cmd_o.month_init = 1'b1;
        end
      end
      S_MONTH:  cmd_o.month_step = status_i.month_more;
      S_DONE:   cmd_o.out_load   = out_free;
      default: ;
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      kind_q      <= RES_BAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/calendar_date_arithmetic_core.sv =====
// Top level of the Gregorian date shift and difference core.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+----------------------------------------
//   input    | in_valid_i / in_stall_o      | opcode, date A, date B, day_offset
//   output   | out_valid_o / out_stall_i    | shifted date, difference, flags
//
// One item is in work at a time. A shift walks years and months after the range
// check: the year walk usually makes three passes through the shared year-start
// unit (four only near a year start), and the month walk steps once through each
// month up to the result month.
// The result register frees the input side: the next item is taken while a
// result still waits. Reset clears the controller and the result valid flag.
`default_nettype none

module calendar_date_arithmetic_core import cda_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   opcode_i,
  input  logic [YearW-1:0]       a_year_i,
  input  logic [MonW-1:0]        a_month_i,
  input  logic [DayW-1:0]        a_day_i,
  input  logic [YearW-1:0]       b_year_i,
  input  logic [MonW-1:0]        b_month_i,
  input  logic [DayW-1:0]        b_day_i,
  input  logic signed [OffW-1:0] day_offset_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [YearW-1:0]       res_year_o,
  output logic [MonW-1:0]        res_month_o,
  output logic [DayW-1:0]        res_day_o,
  output logic signed [OffW-1:0] day_difference_o,
  output logic                   a_before_b_o,
  output logic                   bad_date_o,
  output logic                   out_of_range_o
);

  // Commands flow from the controller, status flows back; nothing else joins them.
  cmd_t    cmd;
  status_t status;

  // Sequence the item: check A (and B), accumulate serials, walk years and months.
  cda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Hold the operands, the year-start unit and the result register.
  cda_dpath u_dpath (
    .clk_i            (clk_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .opcode_i         (opcode_i),
    .a_year_i         (a_year_i),
    .a_month_i        (a_month_i),
    .a_day_i          (a_day_i),
    .b_year_i         (b_year_i),
    .b_month_i        (b_month_i),
    .b_day_i          (b_day_i),
    .day_offset_i     (day_offset_i),
    .res_year_o       (res_year_o),
    .res_month_o      (res_month_o),
    .res_day_o        (res_day_o),
    .day_difference_o (day_difference_o),
    .a_before_b_o     (a_before_b_o),
    .bad_date_o       (bad_date_o),
    .out_of_range_o   (out_of_range_o)
  );

endmodule

`default_nettype wire

// ===== design/cda_checker.sv =====
// Port-level checker for the date arithmetic core, bound to the top level.
`default_nettype none

module cda_port_checker import cda_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic                   opcode_i,
  input logic [YearW-1:0]       a_year_i,
  input logic [MonW-1:0]        a_month_i,
  input logic [DayW-1:0]        a_day_i,
  input logic [YearW-1:0]       b_year_i,
  input logic [MonW-1:0]        b_month_i,
  input logic [DayW-1:0]        b_day_i,
  input logic signed [OffW-1:0] day_offset_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [YearW-1:0]       res_year_o,
  input logic [MonW-1:0]        res_month_o,
  input logic [DayW-1:0]        res_day_o,
  input logic signed [OffW-1:0] day_difference_o,
  input logic                   a_before_b_o,
  input logic                   bad_date_o,
  input logic                   out_of_range_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(res_year_o) &&
      $stable(res_day_o) && $stable(day_difference_o))
    else $error("stalled result changed");

  // An accepted item keeps the input side busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  // A bad date clears every other field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_date_o |-> !out_of_range_o && !a_before_b_o &&
      (res_year_o == '0) && (res_month_o == '0) && (res_day_o == '0) &&
      (day_difference_o == '0))
    else $error("bad date result carries data");

  // A before B means a negative difference.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && a_before_b_o |-> day_difference_o[OffW-1])
    else $error("order flag disagrees with difference sign");

  // A shifted date is a plausible calendar date.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (res_month_o != '0) |-> (res_month_o <= MonthsPerYear) &&
      (res_day_o != '0) && (res_year_o != '0) && (res_year_o <= MaxYear))
    else $error("shifted date out of calendar");

endmodule

bind calendar_date_arithmetic_core cda_port_checker u_cda_checker (.*);

`default_nettype wire

// ===== tb/cda_tb_pkg.sv =====
// Opcode codes shared by the date arithmetic testbench and its checker.
`timescale 1ns / 1ps

package cda_tb_pkg;

  typedef enum logic {
    OP_SHIFT = 1'b0,
    OP_DIFF  = 1'b1
  } op_e;

endpackage

// ===== tb/cda_checker.sv =====
// Result checker of the date arithmetic core: calendar model, result queue and compare.
`timescale 1ns / 1ps

module cda_checker import cda_pkg::*; import cda_tb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic                   opcode_i,
  input  logic [YearW-1:0]       a_year_i,
  input  logic [MonW-1:0]        a_month_i,
  input  logic [DayW-1:0]        a_day_i,
  input  logic [YearW-1:0]       b_year_i,
  input  logic [MonW-1:0]        b_month_i,
  input  logic [DayW-1:0]        b_day_i,
  input  logic signed [OffW-1:0] day_offset_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic [YearW-1:0]       res_year_i,
  input  logic [MonW-1:0]        res_month_i,
  input  logic [DayW-1:0]        res_day_i,
  input  logic signed [OffW-1:0] day_difference_i,
  input  logic                   a_before_b_i,
  input  logic                   bad_date_i,
  input  logic                   out_of_range_i,
  output int unsigned            pending_results_o,
  output int unsigned            mismatch_count_o
);

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [OffW-1:0]  diff;
    logic             earlier;
    logic             bad;
    logic             oor;
  } date_result_t;

  date_result_t pending_results_q[$];
  date_result_t want;
  int unsigned  mismatches = 0;

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_length(input longint y, input longint m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit date_valid(input longint y, input longint m, input longint d);
    if (y < 1 || y > 9999 || m < 1 || m > 12) return 1'b0;
    return d >= 1 && d <= month_length(y, m);
  endfunction

  // Days from 0001-01-01 to January 1 of year y.
  function automatic longint year_base(input longint y);
    longint p;
    p = y - 1;
    return p * 365 + p / 4 - p / 100 + p / 400;
  endfunction

  function automatic longint day_serial(input longint y, input longint m, input longint d);
    longint n;
    n = year_base(y);
    for (longint k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  function automatic date_result_t calc_date_result(
    input op_e op, input longint ay, input longint am, input longint ad,
    input longint by, input longint bm, input longint bd, input longint off);
    date_result_t r;
    longint       n, y, m, diff;
    r = '0;
    if (!date_valid(ay, am, ad) || (op == OP_DIFF && !date_valid(by, bm, bd))) begin
      r.bad = 1'b1;
      return r;
    end
    if (op == OP_SHIFT) begin
      n = day_serial(ay, am, ad) + off;
      if (n < 0 || n >= year_base(10000)) begin
        r.oor = 1'b1;
        return r;
      end
      y = n / 366 + 1;
      while (year_base(y + 1) <= n) y++;
      n -= year_base(y);
      m = 1;
      while (m < 12 && n >= month_length(y, m)) begin
        n -= month_length(y, m);
        m++;
      end
      r.year  = y[YearW-1:0];
      r.month = m[MonW-1:0];
      r.day   = n[DayW-1:0] + 1'b1;
    end else begin
      diff      = day_serial(ay, am, ad) - day_serial(by, bm, bd);
      r.diff    = diff[OffW-1:0];
      r.earlier = diff < 0;
    end
    return r;
  endfunction

  function automatic bit field_differs(input string name, input longint exp_v,
                                       input longint act_v);
    if (exp_v == act_v) return 1'b0;
    $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_results_o <= 0;
      mismatch_count_o  <= 0;
    end else begin
      // Retire first: a result can never belong to the item taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (pending_results_q.size() == 0) begin
          $display("%0t: result with no request waiting, year %0d diff %0d bad %0b",
                   $time, res_year_i, day_difference_i, bad_date_i);
          mismatches++;
        end else begin
          want = pending_results_q.pop_front();
          mismatches += field_differs("res_year", want.year, res_year_i);
          mismatches += field_differs("res_month", want.month, res_month_i);
          mismatches += field_differs("res_day", want.day, res_day_i);
          mismatches += field_differs("day_difference", $signed(want.diff),
                                      day_difference_i);
          mismatches += field_differs("a_before_b", want.earlier, a_before_b_i);
          mismatches += field_differs("bad_date", want.bad, bad_date_i);
          mismatches += field_differs("out_of_range", want.oor, out_of_range_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        pending_results_q.push_back(calc_date_result(op_e'(opcode_i),
          a_year_i, a_month_i, a_day_i, b_year_i, b_month_i, b_day_i,
          day_offset_i));
      end
      pending_results_o <= pending_results_q.size();
      mismatch_count_o  <= mismatches;
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top of the date arithmetic core: clock, reset, request traffic and verdict.
`timescale 1ns / 1ps

module tb;
  import cda_pkg::*;
  import cda_tb_pkg::*;

  localparam int RandomItems = 830;
  localparam int LongHold    = 300;   // receiver hold-off that backs the core up
  localparam int IdleLimit   = 4000;  // cycles with no handshake before giving up
  localparam int DrainCycles = 40;    // idle wait before the verdict, longer than the longest shift
  localparam int LastSerial  = 3652058; // 9999-12-31 counted from 0001-01-01

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   opcode_i;
  logic [YearW-1:0]       a_year_i;
  logic [MonW-1:0]        a_month_i;
  logic [DayW-1:0]        a_day_i;
  logic [YearW-1:0]       b_year_i;
  logic [MonW-1:0]        b_month_i;
  logic [DayW-1:0]        b_day_i;
  logic signed [OffW-1:0] day_offset_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [YearW-1:0]       res_year_o;
  logic [MonW-1:0]        res_month_o;
  logic [DayW-1:0]        res_day_o;
  logic signed [OffW-1:0] day_difference_o;
  logic                   a_before_b_o;
  logic                   bad_date_o;
  logic                   out_of_range_o;

  int unsigned pending_results;
  int unsigned mismatch_count;

  // Shared between the request and result processes: ask for one long hold-off,
  // and switch each side between random gaps and back-to-back stretches.
  bit hold_off_req = 1'b0;
  bit tx_eager     = 1'b0;
  bit rx_eager     = 1'b0;
  int idle_cycles  = 0;

  calendar_date_arithmetic_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .a_year_i         (a_year_i),
    .a_month_i        (a_month_i),
    .a_day_i          (a_day_i),
    .b_year_i         (b_year_i),
    .b_month_i        (b_month_i),
    .b_day_i          (b_day_i),
    .day_offset_i     (day_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .res_year_o       (res_year_o),
    .res_month_o      (res_month_o),
    .res_day_o        (res_day_o),
    .day_difference_o (day_difference_o),
    .a_before_b_o     (a_before_b_o),
    .bad_date_o       (bad_date_o),
    .out_of_range_o   (out_of_range_o)
  );

  cda_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .opcode_i          (opcode_i),
    .a_year_i          (a_year_i),
    .a_month_i         (a_month_i),
    .a_day_i           (a_day_i),
    .b_year_i          (b_year_i),
    .b_month_i         (b_month_i),
    .b_day_i           (b_day_i),
    .day_offset_i      (day_offset_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .res_year_i        (res_year_o),
    .res_month_i       (res_month_o),
    .res_day_i         (res_day_o),
    .day_difference_i  (day_difference_o),
    .a_before_b_i      (a_before_b_o),
    .bad_date_i        (bad_date_o),
    .out_of_range_i    (out_of_range_o),
    .pending_results_o (pending_results),
    .mismatch_count_o  (mismatch_count)
  );

  // 10 ns clock, low half first so the first rising edge comes after time zero.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: count edges at which neither channel moves an item; stop the run
  // once the core has clearly hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, IdleLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Offer one item: wait a random gap with valid low, then hold the payload
  // until the core takes it. Valid stays high after acceptance so a gap-free
  // next item never lowers and raises it in the same step.
  task automatic send_request(input op_e op,
                              input int ay, input int am, input int ad,
                              input int by, input int bm, input int bd,
                              input int off);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 39) == 0) tx_eager = !tx_eager;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode_i     <= op;
    a_year_i     <= ay[YearW-1:0];
    a_month_i    <= am[MonW-1:0];
    a_day_i      <= ad[DayW-1:0];
    b_year_i     <= by[YearW-1:0];
    b_month_i    <= bm[MonW-1:0];
    b_day_i      <= bd[DayW-1:0];
    day_offset_i <= off[OffW-1:0];
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and hold off until every outstanding result has come back.
  // Step one edge first: the count seen at the accept edge misses that item.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
  endtask

  // Years weighted toward the calendar ends and the leap-rule boundaries.
  function automatic int pick_year();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 4);
      1:       return $urandom_range(9996, 9999);
      2:       return 400 * $urandom_range(1, 24);
      3:       return 100 * $urandom_range(1, 99);
      4:       return 4 * $urandom_range(1, 2499);
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  // Mostly safe days; the long-month tail also hits invalid month ends.
  function automatic int pick_day();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 28);
    return $urandom_range(29, 31);
  endfunction

  function automatic int pick_offset();
    case ($urandom_range(0, 5))
      0:       return int'($urandom_range(0, 800)) - 400;
      1:       return int'($urandom_range(0, 200000)) - 100000;
      2:       return int'($urandom_range(0, 2 * LastSerial)) - LastSerial;
      3:       return int'($urandom());  // every offset bit, both signs
      4:       return int'($urandom_range(0, 4)) - 2;
      default: return int'($urandom_range(0, 60)) - 30;
    endcase
  endfunction

  // Result side: per item, stall for a random count, then wait for the take.
  initial begin
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = LongHold;
      end else if (rx_eager) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 16);
      end
      if ($urandom_range(0, 39) == 0) rx_eager = !rx_eager;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Request side and verdict.
  initial begin
    int ay, am, ad, by, bm, bd, off;
    op_e op;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_SHIFT;
    a_year_i     = '0;
    a_month_i    = '0;
    a_day_i      = '0;
    b_year_i     = '0;
    b_month_i    = '0;
    b_day_i      = '0;
    day_offset_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Leap rule: divisible by 400 is leap, by 100 alone is not, by 4 is.
    send_request(OP_SHIFT, 2000, 2, 28, 1, 1, 1, 1);
    send_request(OP_SHIFT, 1900, 2, 28, 1, 1, 1, 1);
    send_request(OP_SHIFT, 2024, 2, 29, 1, 1, 1, 366);
    send_request(OP_SHIFT, 2023, 12, 31, 1, 1, 1, -365);
    // Calendar ends, zero offset and the full span both ways.
    send_request(OP_SHIFT, 1, 1, 1, 1, 1, 1, -1);
    send_request(OP_SHIFT, 9999, 12, 31, 1, 1, 1, 1);
    send_request(OP_SHIFT, 9999, 12, 31, 1, 1, 1, 0);
    send_request(OP_SHIFT, 1, 1, 1, 1, 1, 1, LastSerial);
    send_request(OP_SHIFT, 9999, 12, 31, 1, 1, 1, -LastSerial);
    // Offset field extremes run off the calendar.
    send_request(OP_SHIFT, 1, 1, 1, 1, 1, 1, 4194303);
    send_request(OP_SHIFT, 9999, 12, 31, 1, 1, 1, -4194304);
    // Invalid A: day 0, month 0 and 15, year 0 and all ones, short months.
    send_request(OP_SHIFT, 2023, 5, 0, 1, 1, 1, 5);
    send_request(OP_SHIFT, 2023, 0, 10, 1, 1, 1, 5);
    send_request(OP_SHIFT, 2023, 15, 31, 1, 1, 1, 5);
    send_request(OP_SHIFT, 0, 6, 1, 1, 1, 1, 5);
    send_request(OP_SHIFT, 16383, 6, 1, 1, 1, 1, 5);
    send_request(OP_SHIFT, 2023, 2, 29, 1, 1, 1, 5);
    send_request(OP_SHIFT, 2023, 4, 31, 1, 1, 1, 5);
    // Difference: full span both signs, equal dates, invalid B and A.
    send_request(OP_DIFF, 9999, 12, 31, 1, 1, 1, 0);
    send_request(OP_DIFF, 1, 1, 1, 9999, 12, 31, 0);
    send_request(OP_DIFF, 2024, 2, 29, 2024, 2, 29, 0);
    send_request(OP_DIFF, 2024, 3, 1, 2024, 2, 0, 0);
    send_request(OP_DIFF, 2024, 3, 1, 16383, 15, 31, 0);
    send_request(OP_DIFF, 1900, 2, 29, 1900, 3, 1, 0);
    wait_for_results();

    for (int n = 0; n < RandomItems; n++) begin
      // Pause the sender until the core empties, twice; once ask the
      // receiver for a long hold-off while requests keep coming.
      if (n == 150 || n == 550) wait_for_results();
      if (n == 350) hold_off_req = 1'b1;
      op = $urandom_range(0, 1) ? OP_DIFF : OP_SHIFT;
      if ($urandom_range(0, 99) < 85) begin
        ay = pick_year();
        am = $urandom_range(1, 12);
        ad = pick_day();
      end else begin
        ay = $urandom_range(0, 16383);
        am = $urandom_range(0, 15);
        ad = $urandom_range(0, 31);
      end
      if ($urandom_range(0, 99) < 85) begin
        by = $urandom_range(0, 2) == 0 ? ay : pick_year();
        bm = $urandom_range(1, 12);
        bd = pick_day();
      end else begin
        by = $urandom_range(0, 16383);
        bm = $urandom_range(0, 15);
        bd = $urandom_range(0, 31);
      end
      off = pick_offset();
      send_request(op, ay, am, ad, by, bm, bd, off);
    end

    // Wind down: drain, then let stray results show up before the verdict.
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
